[design/calts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar time step package
// Shared types, field limits and calendar helpers for the calendar time step
// core.
// ----------------------------------------------------------------------------
package calts_pkg;

	typedef enum logic [1:0] {
		KIND_STAMP = 2'd0,
		KIND_DATE  = 2'd1,
		KIND_TOD   = 2'd2
	} kind_t;

	localparam logic ACT_NEXT = 1'b0;
	localparam logic ACT_PREV = 1'b1;

	localparam logic [9:0]  MS_LAST    = 10'd999;
	localparam logic [9:0]  MS_RADIX   = 10'd1000;
	localparam logic [9:0]  SEC_LAST   = 10'd59;
	localparam logic [9:0]  SEC_RADIX  = 10'd60;
	localparam logic [9:0]  HOUR_LAST  = 10'd23;
	localparam logic [3:0]  MONTH_LAST = 4'd12;
	localparam logic [14:0] YEAR_MAX   = 15'd9999;

	// Reciprocal of 25 scaled by 2^17; exact for every 14-bit year.
	localparam logic [12:0] RECIP_25   = 13'd5243;
	localparam int          RECIP_SH   = 17;

	typedef struct packed {
		logic        action;
		kind_t       kind;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  millisecond;
	} step_in_t;

	typedef struct packed {
		logic        valid_res;
		logic [13:0] new_year;
		logic [3:0]  new_month;
		logic [4:0]  new_day;
		logic [4:0]  new_hour;
		logic [5:0]  new_minute;
		logic [5:0]  new_second;
		logic [9:0]  new_millisecond;
	} step_res_t;

	// Leap when divisible by 4 and either not by 25 or also by 16.
	function automatic logic is_leap(input logic [13:0] y);
		logic [26:0] prod;
		logic [9:0]  quo;
		logic [13:0] back;
		logic        div25;
		prod  = 27'(y) * 27'(RECIP_25);
		quo   = prod[26:RECIP_SH];
		back  = {4'b0, quo} * 14'd25;
		div25 = (back == y);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mo);
		logic [4:0] d;
		case (mo) inside
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2:                    d = leap ? 5'd29 : 5'd28;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[design/calendar_time_step_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar time step core
// Gives the Gregorian successor or predecessor of a date-time, date or time
// of day, with full carry and borrow through month lengths and leap years.
// ----------------------------------------------------------------------------
//
// Channel    Handshake           Payload
// request    start / busy        action, kind, year .. millisecond
// result     done (strobe)       valid_res, new_year .. new_millisecond
//
// One beat is taken in every cycle; busy is always low.
// A result passes through the input register, one pass of calendar logic
// (leap-year check by reciprocal multiply) and the result register.
// Reset clears only the two valid flags; payload registers are not reset.
// The result strobe lasts one cycle and cannot be held off by the receiver.
//
module calendar_time_step_core import calts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [1:0]  kind,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	input  logic [9:0]  millisecond,
	output logic        done,
	output logic        valid_res,
	output logic [13:0] new_year,
	output logic [3:0]  new_month,
	output logic [4:0]  new_day,
	output logic [4:0]  new_hour,
	output logic [5:0]  new_minute,
	output logic [5:0]  new_second,
	output logic [9:0]  new_millisecond
);

	logic      vld_s1;
	step_in_t  item_s1;
	step_res_t res_c;
	logic      done_s2;
	step_res_t res_s2;
	logic      take;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= take;
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action      <= action;
			item_s1.kind        <= kind_t'(kind);
			item_s1.year        <= year;
			item_s1.month       <= month;
			item_s1.day         <= day;
			item_s1.hour        <= hour;
			item_s1.minute      <= minute;
			item_s1.second      <= second;
			item_s1.millisecond <= millisecond;
		end
		if (vld_s1) begin
			res_s2 <= res_c;
		end
	end

	calts_step u_step (
		.item (item_s1),
		.res  (res_c)
	);

	assign done            = done_s2;
	assign valid_res       = res_s2.valid_res;
	assign new_year        = res_s2.new_year;
	assign new_month       = res_s2.new_month;
	assign new_day         = res_s2.new_day;
	assign new_hour        = res_s2.new_hour;
	assign new_minute      = res_s2.new_minute;
	assign new_second      = res_s2.new_second;
	assign new_millisecond = res_s2.new_millisecond;

	// A result beat always traces back to a request taken through the input and result registers.
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result strobe without a request");

	// An invalid result carries all-zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (new_year == '0 && new_month == '0 && new_day == '0
			&& new_hour == '0 && new_minute == '0 && new_second == '0
			&& new_millisecond == '0))
		else $error("invalid result with nonzero fields");

	// A valid result never carries a year past the calendar range.
	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && valid_res) |-> ({1'b0, new_year} <= YEAR_MAX))
		else $error("valid result with year out of range");

endmodule

[design/calts_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar time step datapath
// Combinational successor or predecessor of one registered date-time beat.
// ----------------------------------------------------------------------------
module calts_step import calts_pkg::*; (
	input  step_in_t  item,
	output step_res_t res
);

	typedef struct packed {
		logic [9:0] n;
		logic       w;
	} dig_t;

	typedef struct packed {
		logic [9:0]        n;
		logic signed [1:0] c;
	} nrm_t;

	// Field step with plain compare, as used for full date-time stepping.
	function automatic dig_t dig_up(input logic [9:0] x, input logic [9:0] last,
			input logic en);
		logic [10:0] s;
		dig_t        r;
		s   = {1'b0, x} + 11'd1;
		r.n = x;
		r.w = 1'b0;
		if (en) begin
			if (s > {1'b0, last}) begin
				r.n = '0;
				r.w = 1'b1;
			end else begin
				r.n = s[9:0];
			end
		end
		return r;
	endfunction

	function automatic dig_t dig_dn(input logic [9:0] x, input logic [9:0] last,
			input logic en);
		dig_t r;
		r.n = x;
		r.w = 1'b0;
		if (en) begin
			if (x == '0) begin
				r.n = last;
				r.w = 1'b1;
			end else begin
				r.n = x - 10'd1;
			end
		end
		return r;
	endfunction

	// Positional normalization for the time-of-day step: a digit may carry or
	// borrow in either direction because out-of-range fields fold into the total.
	function automatic nrm_t norm(input logic [9:0] x, input logic signed [1:0] cin,
			input logic [9:0] radix);
		logic signed [11:0] v;
		logic signed [11:0] rad;
		nrm_t               r;
		v   = $signed({2'b00, x}) + 12'(cin);
		rad = $signed({2'b00, radix});
		if (v < 0) begin
			r.n = 10'(v + rad);
			r.c = -2'sd1;
		end else if (v >= rad) begin
			r.n = 10'(v - rad);
			r.c = 2'sd1;
		end else begin
			r.n = v[9:0];
			r.c = 2'sd0;
		end
		return r;
	endfunction

	logic fwd;

	dig_t u_ms, u_s, u_mi, u_h;
	dig_t d_ms, d_s, d_mi, d_h;
	logic roll;

	nrm_t               n_ms, n_s, n_mi;
	logic signed [1:0]  cin0;
	logic signed [11:0] h_v;
	logic               tod_ok;

	logic        en_day;
	logic [5:0]  d_up;
	logic [4:0]  mo_up;
	logic        d_bor, mo_bor;
	logic [3:0]  mo_prev;
	logic [3:0]  md_mon;
	logic [13:0] md_year;
	logic [4:0]  mdays;
	logic        d_car, mo_car;
	logic [4:0]  d_n;
	logic [3:0]  mo_n;
	logic [14:0] y15;
	logic        y_ok;

	assign fwd = (item.action == ACT_NEXT);

	// Time field stepping, millisecond through hour, with plain per-field compares.
	assign u_ms = dig_up(item.millisecond, MS_LAST, 1'b1);
	assign u_s  = dig_up({4'b0, item.second}, SEC_LAST, u_ms.w);
	assign u_mi = dig_up({4'b0, item.minute}, SEC_LAST, u_s.w);
	assign u_h  = dig_up({5'b0, item.hour}, HOUR_LAST, u_mi.w);
	assign d_ms = dig_dn(item.millisecond, MS_LAST, 1'b1);
	assign d_s  = dig_dn({4'b0, item.second}, SEC_LAST, d_ms.w);
	assign d_mi = dig_dn({4'b0, item.minute}, SEC_LAST, d_s.w);
	assign d_h  = dig_dn({5'b0, item.hour}, HOUR_LAST, d_mi.w);
	assign roll = fwd ? u_h.w : d_h.w;

	// Time of day: the result stays inside the day only if the hour lands in range.
	assign cin0   = fwd ? 2'sd1 : -2'sd1;
	assign n_ms   = norm(item.millisecond, cin0, MS_RADIX);
	assign n_s    = norm({4'b0, item.second}, n_ms.c, SEC_RADIX);
	assign n_mi   = norm({4'b0, item.minute}, n_s.c, SEC_RADIX);
	assign h_v    = $signed({7'b0, item.hour}) + 12'(n_mi.c);
	assign tod_ok = (h_v >= 0) && (h_v <= $signed({2'b00, HOUR_LAST}));

	// Day step through months and years.
	assign en_day  = (item.kind == KIND_DATE) || roll;
	assign d_up    = {1'b0, item.day} + 6'd1;
	assign mo_up   = {1'b0, item.month} + 5'd1;
	assign d_bor   = en_day && (item.day <= 5'd1);
	assign mo_bor  = d_bor && (item.month <= 4'd1);
	assign mo_prev = mo_bor ? MONTH_LAST : item.month - 4'd1;
	assign md_mon  = fwd ? item.month : mo_prev;
	assign md_year = (!fwd && mo_bor) ? item.year - 14'd1 : item.year;
	assign mdays   = month_days(is_leap(md_year), md_mon);
	assign d_car   = en_day && (d_up > {1'b0, mdays});
	assign mo_car  = d_car && (mo_up > {1'b0, MONTH_LAST});

	always_comb begin
		if (fwd) begin
			d_n  = d_car ? 5'd1 : (en_day ? d_up[4:0] : item.day);
			mo_n = mo_car ? 4'd1 : (d_car ? mo_up[3:0] : item.month);
			y15  = {1'b0, item.year} + {14'b0, mo_car};
		end else begin
			d_n  = d_bor ? mdays : (en_day ? item.day - 5'd1 : item.day);
			mo_n = d_bor ? mo_prev : item.month;
			y15  = {1'b0, item.year} - {14'b0, mo_bor};
		end
	end

	assign y_ok = (y15 >= 15'd1) && (y15 <= YEAR_MAX);

	always_comb begin
		res = '0;
		case (item.kind)
			KIND_STAMP: begin
				if (y_ok) begin
					res.valid_res       = 1'b1;
					res.new_year        = y15[13:0];
					res.new_month       = mo_n;
					res.new_day         = d_n;
					res.new_hour        = fwd ? u_h.n[4:0] : d_h.n[4:0];
					res.new_minute      = fwd ? u_mi.n[5:0] : d_mi.n[5:0];
					res.new_second      = fwd ? u_s.n[5:0] : d_s.n[5:0];
					res.new_millisecond = fwd ? u_ms.n : d_ms.n;
				end
			end
			KIND_DATE: begin
				if (y_ok) begin
					res.valid_res = 1'b1;
					res.new_year  = y15[13:0];
					res.new_month = mo_n;
					res.new_day   = d_n;
				end
			end
			KIND_TOD: begin
				if (tod_ok) begin
					res.valid_res       = 1'b1;
					res.new_hour        = h_v[4:0];
					res.new_minute      = n_mi.n[5:0];
					res.new_second      = n_s.n[5:0];
					res.new_millisecond = n_ms.n;
				end
			end
			default: res = '0;
		endcase
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar time step core testbench
// Drives date-time, date and time-of-day steps in both directions through the
// core: a directed set of calendar edges, then random beats biased toward
// carries and borrows, plus out-of-range noise. Every result is checked field
// by field against an in-bench calendar predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import calts_pkg::*;

	localparam logic [1:0] KIND_UNDEF  = 2'd3;
	localparam int         CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic        action;
		logic [1:0]  kind;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  millisecond;
	} stamp_req_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [1:0]  kind;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [9:0]  millisecond;
	logic        done;
	logic        valid_res;
	logic [13:0] new_year;
	logic [3:0]  new_month;
	logic [4:0]  new_day;
	logic [4:0]  new_hour;
	logic [5:0]  new_minute;
	logic [5:0]  new_second;
	logic [9:0]  new_millisecond;

	step_res_t expected_steps[$];
	step_res_t got_res;
	step_res_t want_res;
	int        mismatch_count = 0;
	int        cycle_count = 0;
	bit        idle_on = 1'b0;

	calendar_time_step_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.kind(kind),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.millisecond(millisecond),
		.done(done),
		.valid_res(valid_res),
		.new_year(new_year),
		.new_month(new_month),
		.new_day(new_day),
		.new_hour(new_hour),
		.new_minute(new_minute),
		.new_second(new_second),
		.new_millisecond(new_millisecond)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int month_length(int y, int mo);
		if (mo < 1 || mo > 12) begin
			return 31;
		end
		case (mo)
			4, 6, 9, 11: return 30;
			2: return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
			default: return 31;
		endcase
	endfunction

	function automatic step_res_t predict_step(stamp_req_t r);
		int        y, mo, d, h, mi, s, ms, total;
		bit        back, ok, roll;
		step_res_t res;
		y = r.year;
		mo = r.month;
		d = r.day;
		h = r.hour;
		mi = r.minute;
		s = r.second;
		ms = r.millisecond;
		back = (r.action == ACT_PREV);
		ok = 1'b0;
		roll = 1'b0;
		res = '0;
		case (r.kind)
			KIND_STAMP: begin
				// Each field compares against its own limit, so out-of-range
				// inputs only carry when they pass that limit.
				if (!back) begin
					ms++;
					if (ms > 999) begin
						ms = 0;
						s++;
						if (s > 59) begin
							s = 0;
							mi++;
							if (mi > 59) begin
								mi = 0;
								h++;
								if (h > 23) begin
									h = 0;
									roll = 1'b1;
								end
							end
						end
					end
				end else begin
					ms--;
					if (ms < 0) begin
						ms = 999;
						s--;
						if (s < 0) begin
							s = 59;
							mi--;
							if (mi < 0) begin
								mi = 59;
								h--;
								if (h < 0) begin
									h = 23;
									roll = 1'b1;
								end
							end
						end
					end
				end
			end
			KIND_DATE: begin
				roll = 1'b1;
				h = 0;
				mi = 0;
				s = 0;
				ms = 0;
			end
			KIND_TOD: begin
				total = ((h * 60 + mi) * 60 + s) * 1000 + ms + (back ? -1 : 1);
				y = 0;
				mo = 0;
				d = 0;
				if (total >= 0 && total <= 86399999) begin
					ok = 1'b1;
					h = total / 3600000;
					total = total % 3600000;
					mi = total / 60000;
					total = total % 60000;
					s = total / 1000;
					ms = total % 1000;
				end
			end
			default: ok = 1'b0;
		endcase
		if (roll) begin
			if (!back) begin
				d++;
				if (d > month_length(y, mo)) begin
					d = 1;
					mo++;
					if (mo > 12) begin
						mo = 1;
						y++;
					end
				end
			end else begin
				d--;
				if (d < 1) begin
					mo--;
					if (mo < 1) begin
						mo = 12;
						y--;
					end
					d = month_length(y, mo);
				end
			end
		end
		if (r.kind == KIND_STAMP || r.kind == KIND_DATE) begin
			ok = (y >= 1 && y <= 9999);
		end
		if (ok) begin
			res.valid_res = 1'b1;
			res.new_year = 14'(y);
			res.new_month = 4'(mo);
			res.new_day = 5'(d);
			res.new_hour = 5'(h);
			res.new_minute = 6'(mi);
			res.new_second = 6'(s);
			res.new_millisecond = 10'(ms);
		end
		return res;
	endfunction

	function automatic stamp_req_t make_req(logic act, logic [1:0] k, int y, int mo, int d,
			int h, int mi, int s, int ms);
		stamp_req_t r;
		r.action = act;
		r.kind = k;
		r.year = 14'(y);
		r.month = 4'(mo);
		r.day = 5'(d);
		r.hour = 5'(h);
		r.minute = 6'(mi);
		r.second = 6'(s);
		r.millisecond = 10'(ms);
		return r;
	endfunction

	// A well-formed beat; with near_edge set the fields lean toward the values
	// that make the step carry or borrow through day, month and year.
	function automatic stamp_req_t rand_legal(logic [1:0] k, bit near_edge);
		stamp_req_t r;
		int         mlen;
		bit         fwd;
		r.action = 1'($urandom_range(0, 1));
		r.kind = k;
		fwd = (r.action == ACT_NEXT);
		case ($urandom_range(0, 5))
			0: r.year = 14'd1;
			1: r.year = 14'd9999;
			2: r.year = 14'd2000;
			3: r.year = 14'd1900;
			4: r.year = 14'($urandom_range(1, 2499) * 4);
			default: r.year = 14'($urandom_range(1, 9999));
		endcase
		r.month = 4'($urandom_range(1, 12));
		if (near_edge && $urandom_range(0, 2) == 0) begin
			r.month = fwd ? MONTH_LAST : 4'd1;
		end
		mlen = month_length(r.year, r.month);
		r.day = 5'($urandom_range(1, mlen));
		if (near_edge && $urandom_range(0, 1) == 1) begin
			r.day = fwd ? 5'(mlen) : 5'd1;
		end
		r.hour = 5'($urandom_range(0, 23));
		r.minute = 6'($urandom_range(0, 59));
		r.second = 6'($urandom_range(0, 59));
		r.millisecond = 10'($urandom_range(0, 999));
		if (near_edge) begin
			if ($urandom_range(0, 3) != 0) r.millisecond = fwd ? 10'd999 : 10'd0;
			if ($urandom_range(0, 3) != 0) r.second = fwd ? 6'd59 : 6'd0;
			if ($urandom_range(0, 3) != 0) r.minute = fwd ? 6'd59 : 6'd0;
			if ($urandom_range(0, 3) != 0) r.hour = fwd ? 5'd23 : 5'd0;
		end
		// Fields the kind ignores get arbitrary bits.
		if (k == KIND_TOD) begin
			r.year = 14'($urandom);
			r.month = 4'($urandom);
			r.day = 5'($urandom);
		end else if (k == KIND_DATE) begin
			r.hour = 5'($urandom);
			r.minute = 6'($urandom);
			r.second = 6'($urandom);
			r.millisecond = 10'($urandom);
		end
		return r;
	endfunction

	function automatic stamp_req_t rand_noise();
		stamp_req_t r;
		r.action = 1'($urandom);
		r.kind = 2'($urandom);
		r.year = 14'($urandom);
		r.month = 4'($urandom);
		r.day = 5'($urandom);
		r.hour = 5'($urandom);
		r.minute = 6'($urandom);
		r.second = 6'($urandom);
		r.millisecond = 10'($urandom);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	// Start stays high from one beat to the next; it is only lowered when an
	// idle burst follows, so it never sees two assignments in one step.
	task automatic send_step(input stamp_req_t r);
		start <= 1'b1;
		action <= r.action;
		kind <= r.kind;
		year <= r.year;
		month <= r.month;
		day <= r.day;
		hour <= r.hour;
		minute <= r.minute;
		second <= r.second;
		millisecond <= r.millisecond;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Results are checked before the beat taken at the same edge is predicted.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
		if (done) begin
			got_res = '{valid_res, new_year, new_month, new_day,
				new_hour, new_minute, new_second, new_millisecond};
			if (expected_steps.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want_res = expected_steps.pop_front();
				check_field("valid_res", got_res.valid_res, want_res.valid_res);
				check_field("new_year", got_res.new_year, want_res.new_year);
				check_field("new_month", got_res.new_month, want_res.new_month);
				check_field("new_day", got_res.new_day, want_res.new_day);
				check_field("new_hour", got_res.new_hour, want_res.new_hour);
				check_field("new_minute", got_res.new_minute, want_res.new_minute);
				check_field("new_second", got_res.new_second, want_res.new_second);
				check_field("new_millisecond", got_res.new_millisecond,
					want_res.new_millisecond);
			end
		end
		if (arst_n && start && !busy) begin
			expected_steps.push_back(predict_step(stamp_req_t'{action, kind, year, month,
				day, hour, minute, second, millisecond}));
		end
	end

	task automatic test_directed_edges();
		idle_on = 1'b0;
		send_step(make_req(ACT_NEXT, KIND_STAMP, 9999, 12, 31, 23, 59, 59, 999));
		send_step(make_req(ACT_PREV, KIND_STAMP, 1, 1, 1, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_STAMP, 2000, 2, 28, 23, 59, 59, 999));
		send_step(make_req(ACT_NEXT, KIND_STAMP, 1900, 2, 28, 23, 59, 59, 999));
		send_step(make_req(ACT_PREV, KIND_STAMP, 2024, 3, 1, 0, 0, 0, 0));
		send_step(make_req(ACT_PREV, KIND_STAMP, 2023, 3, 1, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_STAMP, 2023, 6, 15, 10, 20, 30, 999));
		send_step(make_req(ACT_PREV, KIND_STAMP, 2023, 1, 1, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_DATE, 9999, 12, 31, 0, 0, 0, 0));
		send_step(make_req(ACT_PREV, KIND_DATE, 1, 1, 1, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_DATE, 2000, 2, 29, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_DATE, 2100, 2, 28, 0, 0, 0, 0));
		send_step(make_req(ACT_PREV, KIND_DATE, 2400, 3, 1, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_DATE, 2023, 4, 30, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_TOD, 0, 0, 0, 23, 59, 59, 999));
		send_step(make_req(ACT_PREV, KIND_TOD, 0, 0, 0, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_TOD, 0, 0, 0, 12, 59, 59, 999));
		send_step(make_req(ACT_PREV, KIND_TOD, 0, 0, 0, 13, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_UNDEF, 2023, 6, 15, 10, 20, 30, 400));
		// Out-of-range fields: all-ones in every position, zero dates, a year past the range.
		send_step(make_req(ACT_NEXT, KIND_STAMP, 16383, 15, 31, 31, 63, 63, 1023));
		send_step(make_req(ACT_PREV, KIND_STAMP, 16383, 15, 31, 31, 63, 63, 1023));
		send_step(make_req(ACT_PREV, KIND_DATE, 0, 0, 0, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_DATE, 10000, 6, 10, 0, 0, 0, 0));
		send_step(make_req(ACT_NEXT, KIND_TOD, 16383, 15, 31, 31, 63, 63, 1023));
		send_step(make_req(ACT_PREV, KIND_TOD, 0, 0, 0, 31, 63, 63, 1023));
	endtask

	task automatic test_stamp_steps();
		idle_on = 1'b1;
		repeat (500) send_step(rand_legal(KIND_STAMP, $urandom_range(0, 2) != 0));
	endtask

	task automatic test_date_steps();
		idle_on = 1'b1;
		repeat (450) send_step(rand_legal(KIND_DATE, $urandom_range(0, 1) == 1));
	endtask

	task automatic test_time_steps();
		idle_on = 1'b1;
		repeat (350) send_step(rand_legal(KIND_TOD, $urandom_range(0, 1) == 1));
	endtask

	task automatic test_field_noise();
		idle_on = 1'b1;
		repeat (250) send_step(rand_noise());
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (300) begin
			if ($urandom_range(0, 4) == 0) begin
				send_step(rand_noise());
			end else begin
				send_step(rand_legal(2'($urandom_range(0, 2)), $urandom_range(0, 1) == 1));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_NEXT;
		kind <= KIND_STAMP;
		year <= '0;
		month <= '0;
		day <= '0;
		hour <= '0;
		minute <= '0;
		second <= '0;
		millisecond <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_stamp_steps();
		test_date_steps();
		test_time_steps();
		test_field_noise();
		test_back_to_back();
		start <= 1'b0;
		while (expected_steps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

[files.f]
design/calts_pkg.sv
design/calts_step.sv
design/calendar_time_step_core.sv
bench/tb_top.sv
